### src/blfcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfcb_pkg
// Shared types and constants for the bitmap line fetch and color buffer.
// ----------------------------------------------------------------------------
package blfcb_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_VRAM_MODE        = 3'd0,
    REG_SCROLL_X         = 3'd1,
    REG_SCROLL_Y         = 3'd2,
    REG_SCREEN_TOP       = 3'd3,
    REG_SUBPALETTE       = 3'd4,
    REG_BUFFER_ENABLE    = 3'd5,
    REG_BUFFER_THRESHOLD = 3'd6
  } reg_index_e;

  // Video memory modes; undefined codes behave as the 4-bit 512x512 mode
  typedef enum logic [2:0] {
    MODE_8B_SPLIT_Y = 3'd0,
    MODE_8B_256X512 = 3'd1,
    MODE_4B_SPLIT_Y = 3'd2,
    MODE_4B_SPLIT_X = 3'd3,
    MODE_4B_512X512 = 3'd4
  } vram_mode_e;

  localparam int unsigned CfgDataWidth = 9;
  localparam int unsigned AddrWidth    = 17;

  localparam logic [7:0] PixFull     = 8'hFF;
  localparam logic [7:0] PosLast     = 8'hFF;
  localparam logic [3:0] NibbleFull  = 4'hF;
  localparam logic [3:0] NibbleZero  = 4'h0;

  // Configuration register set
  typedef struct packed {
    logic [2:0] vram_mode;
    logic [8:0] scroll_x;
    logic [8:0] scroll_y;
    logic [8:0] screen_top;
    logic [3:0] subpalette;
    logic       buffer_enable;
    logic [7:0] buffer_threshold;
  } cfg_t;

  // Color buffer update request from the pixel datapath
  typedef struct packed {
    logic       load;
    logic [7:0] color;
  } buf_upd_t;

endpackage

### src/blfcb_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blfcb_pixel
// Address generation and palette index processing for one bitmap pixel.
// ----------------------------------------------------------------------------
module blfcb_pixel import blfcb_pkg::*; (
  input  cfg_t                 cfg_i,
  input  logic [7:0]           line_pos_i,
  input  logic [8:0]           scanline_i,
  input  logic [7:0]           raw_byte_i,
  input  logic [7:0]           buffered_color_i,
  output logic [AddrWidth-1:0] fetch_address_o,
  output logic [7:0]           pixel_index_o,
  output buf_upd_t             buf_upd_o
);

  logic       wide8;
  logic       split_y;
  logic       split_x;
  logic       narrow_w;
  logic       narrow_h;
  logic [8:0] sum_x;
  logic [8:0] sum_y;
  logic [8:0] data_x;
  logic [8:0] data_y;
  logic [3:0] nibble;
  logic [7:0] pix_raw;
  logic [7:0] pix_mask;
  logic [7:0] thr_mask;

  // Decode the memory mode
  always_comb begin
    wide8    = 1'b0;
    split_y  = 1'b0;
    split_x  = 1'b0;
    narrow_w = 1'b0;
    narrow_h = 1'b0;
    case (vram_mode_e'(cfg_i.vram_mode))
      MODE_8B_SPLIT_Y: begin
        wide8    = 1'b1;
        split_y  = 1'b1;
        narrow_w = 1'b1;
        narrow_h = 1'b1;
      end
      MODE_8B_256X512: begin
        wide8    = 1'b1;
        narrow_w = 1'b1;
      end
      MODE_4B_SPLIT_Y: begin
        split_y  = 1'b1;
        narrow_h = 1'b1;
      end
      MODE_4B_SPLIT_X: begin
        split_x  = 1'b1;
        narrow_w = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Form memory coordinates, modulo 512, then apply width, height and split
  assign sum_x = 9'({1'b0, line_pos_i} + cfg_i.scroll_x);
  assign sum_y = 9'(scanline_i + cfg_i.scroll_y - cfg_i.screen_top);

  always_comb begin
    data_x = sum_x;
    if (narrow_w) begin
      data_x[8] = split_x & cfg_i.scroll_x[8];
    end
    data_y = sum_y;
    if (narrow_h) begin
      data_y[8] = split_y & cfg_i.scroll_y[8];
    end
  end

  assign fetch_address_o = wide8 ? {data_y, data_x[7:0]} : {data_y, data_x[8:1]};

  // Pick the nibble by column parity and apply subpalette / fifteen escape
  assign nibble = data_x[0] ? raw_byte_i[3:0] : raw_byte_i[7:4];

  always_comb begin
    if (wide8) begin
      pix_raw = raw_byte_i;
    end else if (nibble == NibbleZero) begin
      pix_raw = 8'h00;
    end else if (nibble == NibbleFull && cfg_i.buffer_enable) begin
      pix_raw = PixFull;
    end else begin
      pix_raw = {cfg_i.subpalette, nibble};
    end
  end

  // Threshold compare on the pixel width
  assign pix_mask = wide8 ? pix_raw : {NibbleZero, pix_raw[3:0]};
  assign thr_mask = wide8 ? cfg_i.buffer_threshold
                          : {NibbleZero, cfg_i.buffer_threshold[3:0]};

  // With buffering on, full-index pixels take the buffered color, or set it
  always_comb begin
    pixel_index_o   = pix_raw;
    buf_upd_o.load  = 1'b0;
    buf_upd_o.color = pix_raw;
    if (cfg_i.buffer_enable) begin
      if (pix_raw == PixFull) begin
        if (line_pos_i != PosLast) begin
          pixel_index_o = buffered_color_i;
        end
      end else if (pix_mask < thr_mask) begin
        buf_upd_o.load = 1'b1;
      end
    end
  end

endmodule

### src/bitmap_line_fetch_color_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_line_fetch_color_buffer_top
// Bitmap layer pixel fetch address and palette index with color buffering.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one pixel request: the
//   position in the fetched line, the screen scanline and the raw bitmap
//   byte. Output channel (out_valid_o / out_ready_i) returns one result per
//   request: the bitmap memory byte address and the processed palette index.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i,
//   one register per cycle, while no request is in flight.
//   A request is held in the input register, then the pixel datapath feeds
//   the result register, which drives out_valid_o. Throughput is one request
//   per cycle while the receiver does not stall; both stages advance
//   together and the color buffer updates as a request leaves the input
//   register, so the next request sees the new color with no bubble.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready_o drops only once both stages are occupied.
//   Reset clears all configuration registers, the buffered color and both
//   valid flags.
// ----------------------------------------------------------------------------
module bitmap_line_fetch_color_buffer_top import blfcb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              line_pos_i,
  input  logic [8:0]              scanline_i,
  input  logic [7:0]              raw_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [AddrWidth-1:0]    fetch_address_o,
  output logic [7:0]              pixel_index_o
);

  cfg_t                 cfg_q;
  logic [7:0]           buf_color_q;
  logic                 s1_valid_q;
  logic [7:0]           s1_pos_q;
  logic [8:0]           s1_line_q;
  logic [7:0]           s1_raw_q;
  logic                 out_valid_q;
  logic [AddrWidth-1:0] out_addr_q;
  logic [7:0]           out_pix_q;
  logic                 s1_adv;
  logic                 in_acc;
  logic [AddrWidth-1:0] dp_addr;
  logic [7:0]           dp_pix;
  buf_upd_t             dp_buf;

  // Handshake: result register frees when empty or taken
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_index_e'(cfg_index_i))
        REG_VRAM_MODE:        cfg_q.vram_mode        <= cfg_data_i[2:0];
        REG_SCROLL_X:         cfg_q.scroll_x         <= cfg_data_i[8:0];
        REG_SCROLL_Y:         cfg_q.scroll_y         <= cfg_data_i[8:0];
        REG_SCREEN_TOP:       cfg_q.screen_top       <= cfg_data_i[8:0];
        REG_SUBPALETTE:       cfg_q.subpalette       <= cfg_data_i[3:0];
        REG_BUFFER_ENABLE:    cfg_q.buffer_enable    <= cfg_data_i[0];
        REG_BUFFER_THRESHOLD: cfg_q.buffer_threshold <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: hold valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input register: capture request payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q  <= line_pos_i;
      s1_line_q <= scanline_i;
      s1_raw_q  <= raw_byte_i;
    end
  end

  blfcb_pixel u_pixel (
    .cfg_i            (cfg_q),
    .line_pos_i       (s1_pos_q),
    .scanline_i       (s1_line_q),
    .raw_byte_i       (s1_raw_q),
    .buffered_color_i (buf_color_q),
    .fetch_address_o  (dp_addr),
    .pixel_index_o    (dp_pix),
    .buf_upd_o        (dp_buf)
  );

  // Color buffer: update as the request leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_color_q <= '0;
    end else if (s1_adv && dp_buf.load) begin
      buf_color_q <= dp_buf.color;
    end
  end

  // Result register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_addr_q <= dp_addr;
      out_pix_q  <= dp_pix;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fetch_address_o = out_addr_q;
  assign pixel_index_o   = out_pix_q;

  // A stalled request stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("input stage lost a stalled request");

  // The buffered color changes only when a request leaves with buffering on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_adv && cfg_q.buffer_enable) |=> $stable(buf_color_q))
    else $error("buffered color changed without a buffered request");

  // Buffering off in 8-bit modes passes the raw byte straight through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !cfg_q.buffer_enable &&
    (cfg_q.vram_mode == MODE_8B_SPLIT_Y || cfg_q.vram_mode == MODE_8B_256X512)
    |=> pixel_index_o == $past(s1_raw_q))
    else $error("8-bit pixel altered with buffering off");

endmodule
